// File: sv/lcp_pkg.sv
// shared constants, types and register indexes for the line clipper
`timescale 1ns / 1ps
package lcp_pkg;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int PW = CB + FB + 1;
    localparam int NST = FB + 5;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [CB:0] wide_t;
    typedef logic [CB-1:0] mag_t;
    typedef logic [FB+1:0] ratio_t;
    typedef logic [FB:0] ufix_t;
    typedef logic [PW-1:0] prod_t;

    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_X_MAX = 2'd1,
        REG_Y_MIN = 2'd2,
        REG_Y_MAX = 2'd3
    } reg_idx_t;

    localparam int B_LEFT = 0;
    localparam int B_RIGHT = 1;
    localparam int B_TOP = 2;
    localparam int B_BOTTOM = 3;

    localparam coord_t X_MIN_RST = coord_t'(0);
    localparam coord_t X_MAX_RST = coord_t'(639);
    localparam coord_t Y_MIN_RST = coord_t'(0);
    localparam coord_t Y_MAX_RST = coord_t'(479);

    localparam ratio_t RATIO_CAP = {2'b10, {FB{1'b0}}};
    localparam ratio_t RATIO_ONE = {2'b01, {FB{1'b0}}};

    typedef struct packed {
        coord_t     sx;
        coord_t     sy;
        mag_t       mag_x;
        mag_t       mag_y;
        logic       neg_x;
        logic       neg_y;
        logic [3:0] p_pos;
        logic [3:0] p_neg;
        logic [3:0] q_neg;
    } seg_t;

endpackage

// File: sv/line_clip_parametric_top.sv
// line clipper top level: window registers, stage handshake and datapath
// datapath: front stage, divider stages, then decision, product and interpolation registers
// throughput: one segment per cycle while out_ready does not stall the output, with one-bit-per-stage divider lanes
// each stage moves when its successor is empty or moving, so bubbles are squeezed out
// reset clears all stage valid bits and loads the window 0..639 by 0..479
`timescale 1ns / 1ps
module line_clip_parametric_top import lcp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  reg_idx_t cfg_index,
    input  coord_t   cfg_data,
    input  logic     in_valid,
    output logic     in_ready,
    input  coord_t   start_x,
    input  coord_t   start_y,
    input  coord_t   end_x,
    input  coord_t   end_y,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     visible,
    output coord_t   clipped_start_x,
    output coord_t   clipped_start_y,
    output coord_t   clipped_end_x,
    output coord_t   clipped_end_y
);

    coord_t x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [NST-1:0] valid_reg, rdy;
    seg_t   seg0;
    mag_t   num0 [4];
    seg_t   seg_reg [1:FB+1];
    ratio_t r [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= X_MIN_RST;
            x_max_reg <= X_MAX_RST;
            y_min_reg <= Y_MIN_RST;
            y_max_reg <= Y_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_MIN: x_min_reg <= cfg_data;
                REG_X_MAX: x_max_reg <= cfg_data;
                REG_Y_MIN: y_min_reg <= cfg_data;
                REG_Y_MAX: y_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rdy[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
            rdy[i] = !valid_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
                if (rdy[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign in_ready = rdy[0];
    assign out_valid = valid_reg[NST-1];

    lcp_front u_front (
        .clk     (clk),
        .en      (rdy[0]),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .x_min   (x_min_reg),
        .x_max   (x_max_reg),
        .y_min   (y_min_reg),
        .y_max   (y_max_reg),
        .seg     (seg0),
        .num     (num0)
    );

    for (genvar b = 0; b < 4; b++)
    begin : g_lane
        lcp_div u_div (
            .clk (clk),
            .en  (rdy[FB+1:1]),
            .num (num0[b]),
            .den ((b < 2) ? seg0.mag_x : seg0.mag_y),
            .quo (r[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            seg_reg[1] <= seg0;
        for (int i = 2; i <= FB + 1; i++)
            if (rdy[i])
                seg_reg[i] <= seg_reg[i-1];
    end

    lcp_interp u_interp (
        .clk             (clk),
        .en              (rdy[FB+4:FB+2]),
        .seg             (seg_reg[FB+1]),
        .r               (r),
        .visible         (visible),
        .clipped_start_x (clipped_start_x),
        .clipped_start_y (clipped_start_y),
        .clipped_end_x   (clipped_end_x),
        .clipped_end_y   (clipped_end_y)
    );

endmodule

// File: sv/lcp_front.sv
// first stage: deltas, boundary distances and their classes
`timescale 1ns / 1ps
module lcp_front import lcp_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    input  coord_t x_min,
    input  coord_t x_max,
    input  coord_t y_min,
    input  coord_t y_max,
    output seg_t   seg,
    output mag_t   num [4]
);

    seg_t  seg_reg, seg_next;
    mag_t  num_reg [4];
    mag_t  num_next [4];
    wide_t dx, dy;
    wide_t q [4];
    wide_t aq [4];
    wide_t adx, ady;

    always_comb
    begin
        dx = wide_t'(end_x) - wide_t'(start_x);
        dy = wide_t'(end_y) - wide_t'(start_y);
        q[B_LEFT] = wide_t'(start_x) - wide_t'(x_min);
        q[B_RIGHT] = wide_t'(x_max) - wide_t'(start_x);
        q[B_TOP] = wide_t'(start_y) - wide_t'(y_min);
        q[B_BOTTOM] = wide_t'(y_max) - wide_t'(start_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        seg_next.sx = start_x;
        seg_next.sy = start_y;
        seg_next.mag_x = adx[CB-1:0];
        seg_next.mag_y = ady[CB-1:0];
        seg_next.neg_x = dx < 0;
        seg_next.neg_y = dy < 0;
        seg_next.p_pos = {dy > 0, dy < 0, dx > 0, dx < 0};
        seg_next.p_neg = {dy < 0, dy > 0, dx < 0, dx > 0};
        for (int i = 0; i < 4; i++)
        begin
            aq[i] = (q[i] < 0) ? -q[i] : q[i];
            num_next[i] = aq[i][CB-1:0];
            seg_next.q_neg[i] = q[i] < 0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_next;
            num_reg <= num_next;
        end
    end

    assign seg = seg_reg;
    assign num = num_reg;

endmodule

// File: sv/lcp_div.sv
// pipelined restoring divider, one quotient bit per stage, capped at 2.0
`timescale 1ns / 1ps
module lcp_div import lcp_pkg::*; (
    input  logic    clk,
    input  logic [FB:0] en,
    input  mag_t    num,
    input  mag_t    den,
    output ratio_t  quo
);

    mag_t  rem_reg [FB+1];
    mag_t  den_reg [FB+1];
    ufix_t quo_reg [FB+1];
    logic  cap_reg [FB+1];

    logic  cap0, ge0;
    mag_t  rem0;

    always_comb
    begin
        cap0 = {1'b0, num} >= {den, 1'b0};
        ge0 = num >= den;
        rem0 = ge0 ? num - den : num;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= rem0;
            den_reg[0] <= den;
            quo_reg[0] <= {{FB{1'b0}}, ge0};
            cap_reg[0] <= cap0;
        end
    end

    for (genvar j = 1; j <= FB; j++)
    begin : g_step
        logic [CB:0] shifted, diff;
        logic        ge;
        mag_t        rem_next;
        ufix_t       quo_next;

        always_comb
        begin
            shifted = {rem_reg[j-1], 1'b0};
            diff = shifted - {1'b0, den_reg[j-1]};
            ge = shifted >= {1'b0, den_reg[j-1]};
            rem_next = ge ? diff[CB-1:0] : shifted[CB-1:0];
            quo_next = {quo_reg[j-1][FB-1:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= quo_next;
                cap_reg[j] <= cap_reg[j-1];
            end
        end
    end

    assign quo = cap_reg[FB] ? RATIO_CAP : {1'b0, quo_reg[FB]};

endmodule

// File: sv/lcp_interp.sv
// window decision, endpoint products and truncated interpolation
`timescale 1ns / 1ps
module lcp_interp import lcp_pkg::*; (
    input  logic     clk,
    input  logic [2:0] en,
    input  seg_t     seg,
    input  ratio_t   r [4],
    output logic     visible,
    output coord_t   clipped_start_x,
    output coord_t   clipped_start_y,
    output coord_t   clipped_end_x,
    output coord_t   clipped_end_y
);

    seg_t   seg_a_reg, seg_b_reg;
    logic   ok_a_reg, ok_b_reg, ok_next;
    ufix_t  u1_reg, u2_reg;
    ratio_t u1, u2;
    logic   reject;
    prod_t  p_sx_reg, p_sy_reg, p_ex_reg, p_ey_reg;
    logic   vis_reg;
    coord_t csx_reg, csy_reg, cex_reg, cey_reg;

    function automatic coord_t lerp(coord_t s, logic neg, prod_t prod);
        logic signed [CB+1:0] t, ipw, one_w;
        logic                 frac;
        ipw = {1'b0, prod[PW-1:FB]};
        one_w = {{(CB+1){1'b0}}, 1'b1};
        frac = |prod[FB-1:0];
        t = neg ? ((CB+2)'(s) - ipw) : ((CB+2)'(s) + ipw);
        if (!neg && t < 0 && frac)
            t = t + one_w;
        if (neg && t > 0 && frac)
            t = t - one_w;
        return t[CB-1:0];
    endfunction

    always_comb
    begin
        u1 = '0;
        u2 = RATIO_ONE;
        reject = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (seg.q_neg[i] && !seg.p_neg[i])
                reject = 1'b1;
            if (seg.p_neg[i] && seg.q_neg[i] && r[i] > u1)
                u1 = r[i];
            if (seg.p_pos[i] && !seg.q_neg[i] && r[i] < u2)
                u2 = r[i];
        end
        ok_next = !reject && (u1 <= u2);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            seg_a_reg <= seg;
            ok_a_reg <= ok_next;
            u1_reg <= u1[FB:0];
            u2_reg <= u2[FB:0];
        end
        if (en[1])
        begin
            seg_b_reg <= seg_a_reg;
            ok_b_reg <= ok_a_reg;
            p_sx_reg <= seg_a_reg.mag_x * u1_reg;
            p_sy_reg <= seg_a_reg.mag_y * u1_reg;
            p_ex_reg <= seg_a_reg.mag_x * u2_reg;
            p_ey_reg <= seg_a_reg.mag_y * u2_reg;
        end
        if (en[2])
        begin
            vis_reg <= ok_b_reg;
            csx_reg <= ok_b_reg ? lerp(seg_b_reg.sx, seg_b_reg.neg_x, p_sx_reg) : '0;
            csy_reg <= ok_b_reg ? lerp(seg_b_reg.sy, seg_b_reg.neg_y, p_sy_reg) : '0;
            cex_reg <= ok_b_reg ? lerp(seg_b_reg.sx, seg_b_reg.neg_x, p_ex_reg) : '0;
            cey_reg <= ok_b_reg ? lerp(seg_b_reg.sy, seg_b_reg.neg_y, p_ey_reg) : '0;
        end
    end

    assign visible = vis_reg;
    assign clipped_start_x = csx_reg;
    assign clipped_start_y = csy_reg;
    assign clipped_end_x = cex_reg;
    assign clipped_end_y = cey_reg;

endmodule

// File: sv/lcp_checker.sv
// port-level checks on the line clipper, bound to the top level
`timescale 1ns / 1ps
module lcp_checker import lcp_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input logic     visible,
    input coord_t   clipped_start_x,
    input coord_t   clipped_start_y,
    input coord_t   clipped_end_x,
    input coord_t   clipped_end_y
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with room in the pipeline");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> clipped_start_x == 0 && clipped_start_y == 0
            && clipped_end_x == 0 && clipped_end_y == 0)
        else $error("rejected word carries coordinates");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result word present out of reset");

endmodule

bind line_clip_parametric_top lcp_checker u_lcp_checker (.*);

// File: tb/tb_top.sv
// self-checking testbench for the parametric line clipper
`timescale 1ns / 1ps
module tb_top;
    import lcp_pkg::*;

    localparam int FRAC = 16;
    localparam longint UNITY = 64'd1 << FRAC;

    typedef struct {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } segment_t;

    typedef struct {
        logic   vis;
        coord_t csx;
        coord_t csy;
        coord_t cex;
        coord_t cey;
    } clip_word_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_valid;
    logic     cfg_ready;
    reg_idx_t cfg_index;
    coord_t   cfg_data;
    logic     in_valid;
    logic     in_ready;
    coord_t   start_x;
    coord_t   start_y;
    coord_t   end_x;
    coord_t   end_y;
    logic     out_valid;
    logic     out_ready;
    logic     visible;
    coord_t   clipped_start_x;
    coord_t   clipped_start_y;
    coord_t   clipped_end_x;
    coord_t   clipped_end_y;

    line_clip_parametric_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .visible(visible),
        .clipped_start_x(clipped_start_x), .clipped_start_y(clipped_start_y),
        .clipped_end_x(clipped_end_x), .clipped_end_y(clipped_end_y)
    );

    longint win_x_min;
    longint win_x_max;
    longint win_y_min;
    longint win_y_max;

    segment_t   pending_segs[$];
    clip_word_t expected_clips[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  send_hold;
    int  mismatches;
    int  segs_sent;
    int  clips_seen;
    int  visible_seen;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic longint frac_ratio(longint n, longint d);
        if (n >= 2 * d)
            return 2 * UNITY;
        return (n * UNITY) / d;
    endfunction

    function automatic longint lerp_coord(longint s, longint d, longint u);
        longint prod;
        longint whole;
        bit     has_frac;
        longint t;
        prod = (d < 0 ? -d : d) * u;
        whole = prod >>> FRAC;
        has_frac = (prod & (UNITY - 1)) != 0;
        if (d >= 0)
        begin
            t = s + whole;
            if (t < 0 && has_frac)
                t = t + 1;
        end
        else
        begin
            t = s - whole;
            if (t > 0 && has_frac)
                t = t - 1;
        end
        return t;
    endfunction

    function automatic bit bound_test(longint p, longint q, ref longint u_in,
                                      ref longint u_out);
        longint r;
        if (p < 0)
        begin
            if (q >= 0)
                return 1'b1;
            r = frac_ratio(-q, -p);
            if (r > u_out)
                return 1'b0;
            if (r > u_in)
                u_in = r;
        end
        else if (p > 0)
        begin
            if (q < 0)
                return 1'b0;
            r = frac_ratio(q, p);
            if (r < u_in)
                return 1'b0;
            if (r < u_out)
                u_out = r;
        end
        return 1'b1;
    endfunction

    function automatic clip_word_t clip_segment(segment_t s);
        clip_word_t w;
        longint sx, sy, dx, dy, u_in, u_out;
        bit ok;
        sx = s.sx;
        sy = s.sy;
        dx = longint'(s.ex) - sx;
        dy = longint'(s.ey) - sy;
        u_in = 0;
        u_out = UNITY;
        ok = 1'b1;
        w = '{1'b0, '0, '0, '0, '0};
        if (dx == 0)
        begin
            if (sx < win_x_min || sx > win_x_max)
                ok = 1'b0;
        end
        else
        begin
            ok = ok && bound_test(-dx, sx - win_x_min, u_in, u_out);
            ok = ok && bound_test(dx, win_x_max - sx, u_in, u_out);
        end
        if (dy == 0)
        begin
            if (sy < win_y_min || sy > win_y_max)
                ok = 1'b0;
        end
        else
        begin
            ok = ok && bound_test(-dy, sy - win_y_min, u_in, u_out);
            ok = ok && bound_test(dy, win_y_max - sy, u_in, u_out);
        end
        if (ok && u_in > u_out)
            ok = 1'b0;
        if (ok)
        begin
            w.vis = 1'b1;
            w.csx = coord_t'(lerp_coord(sx, dx, u_in));
            w.csy = coord_t'(lerp_coord(sy, dy, u_in));
            w.cex = coord_t'(lerp_coord(sx, dx, u_out));
            w.cey = coord_t'(lerp_coord(sy, dy, u_out));
        end
        return w;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            start_x <= '0;
            start_y <= '0;
            end_x <= '0;
            end_y <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_segs.size() > 0 && !send_hold
                && $urandom_range(99) >= send_idle_pct)
            begin
                segment_t s;
                s = pending_segs.pop_front();
                expected_clips.push_back(clip_segment(s));
                segs_sent++;
                in_valid <= 1'b1;
                start_x <= s.sx;
                start_y <= s.sy;
                end_x <= s.ex;
                end_y <= s.ey;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                clips_seen++;
                if (expected_clips.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word at %0t", $realtime);
                end
                else
                begin
                    clip_word_t e;
                    e = expected_clips.pop_front();
                    if (e.vis)
                        visible_seen++;
                    if (visible !== e.vis || clipped_start_x !== e.csx
                        || clipped_start_y !== e.csy || clipped_end_x !== e.cex
                        || clipped_end_y !== e.cey)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0b %0d %0d %0d %0d got %0b %0d %0d %0d %0d",
                                e.vis, e.csx, e.csy, e.cex, e.cey, visible,
                                clipped_start_x, clipped_start_y, clipped_end_x,
                                clipped_end_y);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_segs.size() > 0 || expected_clips.size() > 0 || in_valid)
            @(posedge clk);
        repeat (FB + 10) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, coord_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_X_MIN: win_x_min = val;
            REG_X_MAX: win_x_max = val;
            REG_Y_MIN: win_y_min = val;
            default:   win_y_max = val;
        endcase
    endtask

    task automatic set_window(int x0, int x1, int y0, int y1);
        write_reg(REG_X_MIN, coord_t'(x0));
        write_reg(REG_X_MAX, coord_t'(x1));
        write_reg(REG_Y_MIN, coord_t'(y0));
        write_reg(REG_Y_MAX, coord_t'(y1));
    endtask

    task automatic add_seg(int sx, int sy, int ex, int ey);
        pending_segs.push_back('{coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey)});
    endtask

    function automatic int pick_coord(longint lo, longint hi);
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return int'(lo) - 200 + int'($urandom_range(int'(hi - lo) + 400));
        if (sel < 8)
            return $urandom_range(1) ? int'(lo) + $urandom_range(2) - 1
                                     : int'(hi) + $urandom_range(2) - 1;
        return int'($signed(16'($urandom)));
    endfunction

    task automatic add_random(int n);
        int sx, sy, ex, ey, k;
        longint lx, hx, ly, hy;
        lx = win_x_min; hx = win_x_max; ly = win_y_min; hy = win_y_max;
        if (hx < lx) begin lx = win_x_max; hx = win_x_min; end
        if (hy < ly) begin ly = win_y_max; hy = win_y_min; end
        if (hx - lx > 20000) begin lx = -10000; hx = 10000; end
        if (hy - ly > 20000) begin ly = -10000; hy = 10000; end
        for (int i = 0; i < n; i++)
        begin
            sx = pick_coord(lx, hx);
            sy = pick_coord(ly, hy);
            ex = pick_coord(lx, hx);
            ey = pick_coord(ly, hy);
            k = $urandom_range(19);
            if (k == 0) ex = sx;
            if (k == 1) ey = sy;
            if (k == 2) begin ex = sx; ey = sy; end
            add_seg(sx, sy, ex, ey);
        end
    endtask

    initial
    begin
        #500_000_000;
        $display("line_clip_parametric_top verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_MIN;
        cfg_data = '0;
        send_hold = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 53;
        mismatches = 0;
        segs_sent = 0;
        clips_seen = 0;
        visible_seen = 0;
        win_x_min = 0; win_x_max = 639; win_y_min = 0; win_y_max = 479;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (FB + 10) @(posedge clk);

        // reset window, directed corners
        add_seg(-100, 240, 800, 240);
        add_seg(320, -50, 320, 600);
        add_seg(700, 10, 700, 400);
        add_seg(-5, -5, -5, -5);
        add_seg(639, 479, 639, 479);
        add_seg(100, 100, 100, 100);
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, -32768, -32768, 32767);
        add_seg(-10, 0, 0, -10);
        add_seg(-1, -1, 640, 480);
        add_seg(700, 500, 800, 600);
        add_seg(10, 20, 600, 470);
        add_seg(600, 470, 10, 20);
        add_seg(-32768, 0, -32768, 0);
        add_seg(32767, 32767, -32768, -32768);
        add_seg(0, 479, 639, 0);
        wait_drained();

        // sender pauses mid-stream until every result is back
        add_random(200);
        while (pending_segs.size() > 100)
            @(posedge clk);
        send_hold = 1'b1;
        while (expected_clips.size() > 0)
            @(posedge clk);
        send_hold = 1'b0;
        wait_drained();

        set_window(-32768, 32767, -32768, 32767);
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, 0, -32768, 5);
        add_random(100);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 22;
        set_window(-50, 50, 10, 13);
        add_random(150);
        wait_drained();

        set_window(100, -100, 5, 5);
        add_seg(0, 5, 0, 5);
        add_random(40);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(-1000, 3000, -2000, 700);
        add_random(200);
        wait_drained();

        $display("sent %0d segments, checked %0d results (%0d visible)",
                 segs_sent, clips_seen, visible_seen);
        $display("windows: reset, full range, narrow, inverted, offset");
        if (mismatches == 0 && expected_clips.size() == 0)
            $display("line_clip_parametric_top verification clean");
        else
            $display("line_clip_parametric_top verification failed");
        $finish;
    end
endmodule

// File: sim.f
sv/lcp_pkg.sv
sv/lcp_front.sv
sv/lcp_div.sv
sv/lcp_interp.sv
sv/line_clip_parametric_top.sv
sv/lcp_checker.sv
tb/tb_top.sv
